@@ rtl/core/lzss_pkg.sv @@
// Shared types and constants for the LZSS ring decompressor.
// No dependencies; every other file in rtl/core except lzss_ram refers to it by scoped names.
`default_nettype none

package lzss_pkg;

  // Ring window; the match word carries a 12-bit start position, so the depth is fixed.
  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);

  // Run length counters start at 3..18 and count down.
  localparam int unsigned RUN_W   = 5;
  localparam logic [RUN_W-1:0] MIN_RUN = RUN_W'(3);

  // Flag index runs 0..8; eight flags per control byte.
  localparam int unsigned FIDX_W = 4;
  localparam logic [FIDX_W-1:0] FLAGS_PER_CTRL = FIDX_W'(8);

  localparam int unsigned CNT_W = 32;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_stream;
  } lzss_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
  } lzss_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic restart;     // clear pointers, count, flags
    logic load_flags;  // take in_byte as control byte
    logic literal;     // emit in_byte and store it in the ring
    logic load_high;   // hold first match byte
    logic start_copy;  // second match byte: set up the run
    logic copy_en;     // run the copy pipeline
    logic adv_flag;    // advance flag index
  } lzss_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic flag_bit;       // current flag
    logic len_zero;       // configured length is zero
    logic count_reached;  // byte count already at length
    logic done_next;      // count reaches length with the byte emitted now
    logic last_flag;      // current flag is the eighth
    logic out_free;       // output register can take a byte this cycle
    logic copy_last;      // final byte of the run emitted this cycle
  } lzss_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/lzss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lzss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/lzss_ctrl.sv @@
// Decode-phase state machine of the LZSS ring decompressor.
// Depends on lzss_pkg (command and status structs).
`default_nettype none

module lzss_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_sos,
  output logic                     in_ready,
  input  wire lzss_pkg::lzss_stat_t stat,
  output lzss_pkg::lzss_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_CTRL = 5'b00001,
    ST_ITEM = 5'b00010,
    ST_MLOW = 5'b00100,
    ST_COPY = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt, after_item;
  logic   eff_ctrl, is_item, is_mlow, acc;

  // Start of stream forces the control-byte phase from any state but ST_COPY, where no input is taken.
  assign eff_ctrl = in_sos || (state_r == ST_CTRL);
  assign is_item  = !in_sos && (state_r == ST_ITEM);
  assign is_mlow  = !in_sos && (state_r == ST_MLOW);

  // Only a literal needs the output register at accept time.
  assign in_ready = (state_r != ST_COPY) && (!(is_item && stat.flag_bit) || stat.out_free);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.restart    = acc && in_sos;
    cmd.load_flags = acc && eff_ctrl;
    cmd.literal    = acc && is_item && stat.flag_bit;
    cmd.load_high  = acc && is_item && !stat.flag_bit;
    cmd.start_copy = acc && is_mlow;
    cmd.copy_en    = (state_r == ST_COPY);
    cmd.adv_flag   = cmd.literal || stat.copy_last;
  end

  always_comb begin
    if (stat.done_next) begin
      after_item = ST_DONE;
    end else if (stat.last_flag) begin
      after_item = ST_CTRL;
    end else begin
      after_item = ST_ITEM;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (state_r == ST_COPY) begin
      if (stat.copy_last) begin
        state_nxt = after_item;
      end
    end else if (acc) begin
      if (eff_ctrl) begin
        if (in_sos ? stat.len_zero : stat.count_reached) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ITEM;
        end
      end else begin
        unique case (state_r)
          ST_ITEM: begin
            state_nxt = stat.flag_bit ? after_item : ST_MLOW;
          end
          ST_MLOW: begin
            state_nxt = ST_COPY;
          end
          default: begin
            state_nxt = state_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CTRL;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lzss_dp.sv @@
// Datapath of the LZSS ring decompressor: ring RAM, pointers, counters, output register.
// Depends on lzss_pkg and lzss_ram.
`default_nettype none

module lzss_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lzss_pkg::lzss_in_t              in_data,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lzss_pkg::CNT_W-1:0]      cfg_wr_data,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output lzss_pkg::lzss_out_t                  out_data,
  input  wire lzss_pkg::lzss_cmd_t             cmd,
  output lzss_pkg::lzss_stat_t                 stat
);

  localparam int unsigned AW = lzss_pkg::RING_AW;
  localparam int unsigned RW = lzss_pkg::RUN_W;
  localparam int unsigned FW = lzss_pkg::FIDX_W;
  localparam int unsigned CW = lzss_pkg::CNT_W;

  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] bw_r, bw_nxt, bw_inc;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [FW-1:0] fidx_r, fidx_nxt;
  logic [7:0]    mhb_r, mhb_nxt;
  logic [RW-1:0] issue_left_r, issue_left_nxt;
  logic [RW-1:0] emit_left_r, emit_left_nxt;
  logic          pend_r, pend_nxt;
  logic          byp_r, byp_nxt;
  logic [7:0]    byp_data_r, byp_data_nxt;
  logic          out_valid_r, out_valid_nxt;
  lzss_pkg::lzss_out_t out_data_r, out_data_nxt;

  logic          out_free, emit, issue, wr_en, copy_last, done_next;
  logic [7:0]    ram_rdata, copy_byte, wr_byte;
  logic [RW-1:0] run_len;

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (lzss_pkg::RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (wr_byte),
    .rd_en   (issue),
    .rd_addr (rp_r),
    .rd_data (ram_rdata)
  );

  // Saturating byte count and end check shared by literals and copies.
  assign bw_inc    = (&bw_r) ? bw_r : bw_r + CW'(1);
  assign done_next = bw_inc >= len_r;

  assign out_free  = !out_valid_r || out_ready;
  assign emit      = cmd.copy_en && pend_r && out_free;
  assign issue     = cmd.copy_en && (issue_left_r != '0) && (!pend_r || emit);
  assign copy_last = emit && (emit_left_r == RW'(1));

  // Read issued in the same cycle as a write to that entry returns the old byte: forward.
  assign copy_byte = byp_r ? byp_data_r : ram_rdata;
  assign wr_en     = cmd.literal || emit;
  assign wr_byte   = cmd.literal ? in_data.in_byte : copy_byte;
  assign run_len   = RW'(in_data.in_byte[3:0]) + lzss_pkg::MIN_RUN;

  always_comb begin
    stat               = '0;
    stat.flag_bit      = flags_r[fidx_r[2:0]];
    stat.len_zero      = (len_r == '0);
    stat.count_reached = (bw_r >= len_r);
    stat.done_next     = done_next;
    stat.last_flag     = (fidx_r + FW'(1)) >= lzss_pkg::FLAGS_PER_CTRL;
    stat.out_free      = out_free;
    stat.copy_last     = copy_last;
  end

  always_comb begin
    len_nxt        = cfg_wr_en ? cfg_wr_data : len_r;
    bw_nxt         = bw_r;
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    flags_nxt      = flags_r;
    fidx_nxt       = fidx_r;
    mhb_nxt        = mhb_r;
    issue_left_nxt = issue_left_r;
    emit_left_nxt  = emit_left_r;
    pend_nxt       = pend_r;
    byp_nxt        = byp_r;
    byp_data_nxt   = byp_data_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (cmd.restart) begin
      bw_nxt    = '0;
      wp_nxt    = '0;
      rp_nxt    = '0;
      flags_nxt = '0;
      fidx_nxt  = '0;
      mhb_nxt   = '0;
    end
    if (cmd.load_flags) begin
      flags_nxt = in_data.in_byte;
      fidx_nxt  = '0;
    end
    if (cmd.adv_flag) begin
      fidx_nxt = fidx_r + FW'(1);
    end
    if (cmd.load_high) begin
      mhb_nxt = in_data.in_byte;
    end
    if (cmd.start_copy) begin
      rp_nxt         = {mhb_r, in_data.in_byte[7:4]};
      issue_left_nxt = run_len;
      emit_left_nxt  = run_len;
      pend_nxt       = 1'b0;
      byp_nxt        = 1'b0;
    end
    if (issue) begin
      rp_nxt         = rp_r + AW'(1);
      issue_left_nxt = issue_left_r - RW'(1);
      byp_nxt        = emit && (rp_r == wp_r);
      byp_data_nxt   = wr_byte;
      pend_nxt       = 1'b1;
    end else if (emit) begin
      pend_nxt = 1'b0;
    end
    if (emit) begin
      emit_left_nxt = emit_left_r - RW'(1);
    end
    if (wr_en) begin
      wp_nxt                   = wp_r + AW'(1);
      bw_nxt                   = bw_inc;
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_byte    = wr_byte;
      out_data_nxt.last_of_run = cmd.literal || copy_last;
      out_data_nxt.stream_done = done_next;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      bw_r         <= '0;
      wp_r         <= '0;
      rp_r         <= '0;
      flags_r      <= '0;
      fidx_r       <= '0;
      mhb_r        <= '0;
      issue_left_r <= '0;
      emit_left_r  <= '0;
      pend_r       <= 1'b0;
      byp_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      bw_r         <= bw_nxt;
      wp_r         <= wp_nxt;
      rp_r         <= rp_nxt;
      flags_r      <= flags_nxt;
      fidx_r       <= fidx_nxt;
      mhb_r        <= mhb_nxt;
      issue_left_r <= issue_left_nxt;
      emit_left_r  <= emit_left_nxt;
      pend_r       <= pend_nxt;
      byp_r        <= byp_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= byp_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/core/lzss_ring_decompressor.sv @@
// Top level of the LZSS ring decompressor (4096-byte window).
// Depends on lzss_pkg, lzss_ctrl and lzss_dp (which holds lzss_ram).
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one compressed byte per item;
//   set start_of_stream on the first control byte of a stream to restart decoding.
//   Result channel (out_valid/out_ready/out_data) carries one decompressed byte per item,
//   with last_of_run on the final byte caused by an input item and stream_done once the
//   byte count has reached output_length.
//   cfg_wr_en/cfg_wr_data write output_length; write it only while the block is idle.
// Accept and output timing:
//   Control bytes, first match bytes and bytes after the end never wait for the output.
//   A literal is taken once the output register is free and shows on the output the next cycle.
//   The second match byte starts a run of n = 3..18 bytes, which follow at one byte per
//   cycle unless the receiver stalls; the input is held off until the last byte of the run
//   is emitted. The registered ring RAM read sets the startup; its single write port sets
//   the one-byte-per-cycle run rate.
// Reset:
//   rst_n (synchronous, active low) clears pointers, byte count, flags and output_length
//   and waits for a control byte. Ring contents are not cleared; a match must only
//   reference bytes written since reset.
// Receiver stall:
//   The output register holds its byte while out_ready is low. The run pauses in place,
//   and a literal waits at the input until the output register frees up.
`default_nettype none

module lzss_ring_decompressor (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire lzss_pkg::lzss_in_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output lzss_pkg::lzss_out_t              out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic [lzss_pkg::CNT_W-1:0]  cfg_wr_data
);

  lzss_pkg::lzss_cmd_t  cmd;
  lzss_pkg::lzss_stat_t stat;

  // Phase sequencing: control byte, flag items, match low byte, copy, done.
  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_sos   (in_data.start_of_stream),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Ring, pointers, counters and the output register.
  lzss_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire

@@ rtl/core/lzss_chk.sv @@
// Port-level checker for the LZSS ring decompressor, bound to the top level.
// Depends on lzss_pkg.
`default_nettype none

module lzss_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire lzss_pkg::lzss_out_t out_data
);

  // Output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Stalled output holds valid.
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  // Stalled output holds its byte.
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output item changed while stalled");

  // A byte that is not the last of its run means a copy is in progress: no input taken.
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |-> !in_ready)
    else $error("input ready during a copy run");

endmodule

bind lzss_ring_decompressor lzss_chk u_lzss_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
